>>> sv/lhxbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhxbp_pkg
// Sizes, types and the counter update function shared by the local history
// XOR branch predictor files.
// ----------------------------------------------------------------------------
package lhxbp_pkg;

  localparam int ADDR_W       = 32;
  localparam int HIST_ENTRIES = 1024;
  localparam int CTR_ENTRIES  = 4096;
  localparam int HIST_IDX_W   = $clog2(HIST_ENTRIES);
  localparam int CTR_IDX_W    = $clog2(CTR_ENTRIES);
  // Each history entry keeps only the bits that reach the counter index.
  localparam int HIST_W       = CTR_IDX_W;
  // Word-address bits that reach either index.
  localparam int WORD_W       = (CTR_IDX_W > HIST_IDX_W) ? CTR_IDX_W : HIST_IDX_W;
  localparam int CTR_W        = 2;
  localparam int CONF_W       = 3;

  localparam logic [CTR_W-1:0] CTR_MAX = 2'd3;
  localparam logic [CTR_W-1:0] CTR_MIN = 2'd0;

  localparam logic KIND_PREDICT = 1'b0;
  localparam logic KIND_RESOLVE = 1'b1;

  typedef struct packed {
    logic                  hist_re;
    logic [HIST_IDX_W-1:0] hist_addr;
    logic                  ctr_re;
    logic [CTR_IDX_W-1:0]  ctr_addr;
  } tbl_rd_t;

  typedef struct packed {
    logic                  we;
    logic [HIST_IDX_W-1:0] hist_addr;
    logic [HIST_W-1:0]     hist_data;
    logic [CTR_IDX_W-1:0]  ctr_addr;
    logic [CTR_W-1:0]      ctr_data;
  } tbl_wr_t;

  // Move a 2-bit counter one step toward the outcome, saturating.
  function automatic logic [CTR_W-1:0] ctr_next(input logic [CTR_W-1:0] c,
                                                input logic             taken);
    logic [CTR_W-1:0] n;
    n = c;
    if (taken) begin
      if (c != CTR_MAX) n = c + 2'd1;
    end else begin
      if (c != CTR_MIN) n = c - 2'd1;
    end
    return n;
  endfunction

endpackage

>>> sv/lhxbp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhxbp_in_if
// Branch request channel: kind, byte address and resolved outcome.
// ----------------------------------------------------------------------------
interface lhxbp_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [lhxbp_pkg::ADDR_W-1:0] branch_address;
  logic                         taken;

  modport source (output valid, kind, branch_address, taken, input ready);
  modport sink   (input valid, kind, branch_address, taken, output ready);
endinterface

>>> sv/lhxbp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhxbp_out_if
// Prediction channel: direction and confidence.
// ----------------------------------------------------------------------------
interface lhxbp_out_if;
  logic                         valid;
  logic                         ready;
  logic                         prediction;
  logic [lhxbp_pkg::CONF_W-1:0] confidence;

  modport source (output valid, prediction, confidence, input ready);
  modport sink   (input valid, prediction, confidence, output ready);
endinterface

>>> sv/lhxbp_tables.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhxbp_tables
// Local history and pattern counter memories with registered reads and a
// zeroing sweep after reset.
// ----------------------------------------------------------------------------
module lhxbp_tables (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  lhxbp_pkg::tbl_rd_t                     rd_i,
  input  lhxbp_pkg::tbl_wr_t                     wr_i,
  output logic [lhxbp_pkg::HIST_W-1:0]           hist_rdata_o,
  output logic [lhxbp_pkg::CTR_W-1:0]            ctr_rdata_o,
  output logic                                   busy_o
);
  import lhxbp_pkg::*;

  logic [HIST_W-1:0] hist_mem [HIST_ENTRIES];
  logic [CTR_W-1:0]  ctr_mem  [CTR_ENTRIES];

  logic [HIST_W-1:0] hist_rdata_q;
  logic [CTR_W-1:0]  ctr_rdata_q;

  logic              clr_busy_q, clr_busy_d;
  logic [WORD_W-1:0] clr_cnt_q, clr_cnt_d;

  logic                  hist_we, ctr_we;
  logic [HIST_IDX_W-1:0] hist_waddr;
  logic [CTR_IDX_W-1:0]  ctr_waddr;
  logic [HIST_W-1:0]     hist_wdata;
  logic [CTR_W-1:0]      ctr_wdata;

  // Sweep every counter entry once (each history entry four times), then hand the ports to the datapath.
  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == {WORD_W{1'b1}}) clr_busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  always_comb begin
    if (clr_busy_q) begin
      hist_we    = 1'b1;
      ctr_we     = 1'b1;
      hist_waddr = clr_cnt_q[HIST_IDX_W-1:0];
      ctr_waddr  = clr_cnt_q[CTR_IDX_W-1:0];
      hist_wdata = '0;
      ctr_wdata  = '0;
    end else begin
      hist_we    = wr_i.we;
      ctr_we     = wr_i.we;
      hist_waddr = wr_i.hist_addr;
      ctr_waddr  = wr_i.ctr_addr;
      hist_wdata = wr_i.hist_data;
      ctr_wdata  = wr_i.ctr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    if (rd_i.hist_re) hist_rdata_q <= hist_mem[rd_i.hist_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ctr_we) ctr_mem[ctr_waddr] <= ctr_wdata;
    if (rd_i.ctr_re) ctr_rdata_q <= ctr_mem[rd_i.ctr_addr];
  end

  assign hist_rdata_o = hist_rdata_q;
  assign ctr_rdata_o  = ctr_rdata_q;
  assign busy_o       = clr_busy_q;

endmodule

>>> sv/local_history_xor_branch_predictor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_history_xor_branch_predictor
// Two-level branch predictor: per-address local history, XOR-indexed shared
// table of 2-bit saturating counters.
// ----------------------------------------------------------------------------
// Each transaction on in_i carries a byte address; bits 1:0 are dropped. The
// low word-address bits select a local history entry, and that history XOR
// the word address selects a 2-bit counter. The result on out_o gives the
// counter's upper bit as the prediction and twice the counter as confidence,
// both as they stood before any update. A resolve transaction then steps the
// counter toward the outcome (saturating at 0 and 3) and shifts the outcome
// into the history. The result register loads after two registered reads:
// the history memory read at the accepting edge, then the counter memory
// read, then the result load and the write-back to both memories. A new
// request is taken no earlier than the cycle after the result load. One
// item is in flight at a time, so a write-back always lands before the next
// item's reads and no forwarding is needed. A new request is taken while a
// finished result still waits on out_o; the counter stage holds only when
// that result is still unread. After reset both memories are zeroed by a
// sweep over the 4096 counter indices (one entry of each memory per cycle),
// during which in_i is not ready.
// ----------------------------------------------------------------------------
module local_history_xor_branch_predictor (
  input  logic clk_i,
  input  logic rst_ni,
  lhxbp_in_if.sink    in_i,
  lhxbp_out_if.source out_o
);
  import lhxbp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HIST = 2'd1;
  localparam logic [1:0] ST_CTR  = 2'd2;

  logic [1:0] state_q, state_d;

  // Request held while it walks through the two reads.
  logic              kind_q, taken_q;
  logic [WORD_W-1:0] word_q;
  logic [HIST_W-1:0] hist_q;
  logic [CTR_IDX_W-1:0] ci_q;

  // Result register.
  logic              out_valid_q, out_valid_d;
  logic              pred_q;
  logic [CONF_W-1:0] conf_q;

  tbl_rd_t           tbl_rd;
  tbl_wr_t           tbl_wr;
  logic [HIST_W-1:0] hist_rdata;
  logic [CTR_W-1:0]  ctr_rdata;
  logic              tbl_busy;

  logic              in_acc;
  logic              load_out;
  logic [CTR_IDX_W-1:0] ci_next;

  lhxbp_tables u_tables (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_i        (tbl_rd),
    .wr_i        (tbl_wr),
    .hist_rdata_o(hist_rdata),
    .ctr_rdata_o (ctr_rdata),
    .busy_o      (tbl_busy)
  );

  assign in_i.ready = (state_q == ST_IDLE) && !tbl_busy;
  assign in_acc     = in_i.valid && in_i.ready;

  // Counter stage finishes when the result slot is free or being emptied.
  assign load_out = (state_q == ST_CTR) && (!out_valid_q || out_o.ready);

  assign ci_next = hist_rdata ^ word_q[CTR_IDX_W-1:0];

  // Read the history on acceptance, the counter in the following cycle.
  always_comb begin
    tbl_rd.hist_re   = in_acc;
    tbl_rd.hist_addr = in_i.branch_address[HIST_IDX_W+1:2];
    tbl_rd.ctr_re    = (state_q == ST_HIST);
    tbl_rd.ctr_addr  = ci_next;
  end

  // Write back both entries when a resolve completes.
  always_comb begin
    tbl_wr.we        = load_out && (kind_q == KIND_RESOLVE);
    tbl_wr.hist_addr = word_q[HIST_IDX_W-1:0];
    tbl_wr.hist_data = {hist_q[HIST_W-2:0], taken_q};
    tbl_wr.ctr_addr  = ci_q;
    tbl_wr.ctr_data  = ctr_next(ctr_rdata, taken_q);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc)   state_d = ST_HIST;
      ST_HIST:               state_d = ST_CTR;
      ST_CTR:  if (load_out) state_d = ST_IDLE;
      default:               state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out)          out_valid_d = 1'b1;
    else if (out_o.ready)  out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: capture the request, the history and the result.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q  <= in_i.kind;
      taken_q <= in_i.taken;
      word_q  <= in_i.branch_address[WORD_W+1:2];
    end
    if (state_q == ST_HIST) begin
      hist_q <= hist_rdata;
      ci_q   <= ci_next;
    end
    if (load_out) begin
      pred_q <= ctr_rdata[CTR_W-1];
      conf_q <= {ctr_rdata, 1'b0};
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.prediction = pred_q;
  assign out_o.confidence = conf_q;

endmodule
